FILE: sv/hbpa_pkg.sv
// shared types and constants of the homography back-projection block
// no dependencies
`timescale 1ns / 1ps

package hbpa_pkg;

    localparam int COEF_W     = 32;
    localparam int COEF_IDX_W = 4;
    localparam int NUM_COEF   = 9;
    localparam int PA_W       = 27;
    localparam int AREA_W     = 40;
    localparam int WORLD_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_DIV    = 6;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_OBJECT = 1'b1
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_X = 2'd0,
        CFG_SHIFT_Y = 2'd1,
        CFG_AREA_EN = 2'd2
    } t_cfg_index;

endpackage

FILE: sv/hbpa_in_if.sv
// request channel: coefficient loads and object items
// depends on hbpa_pkg
`timescale 1ns / 1ps

interface hbpa_in_if
    import hbpa_pkg::*;
#(
    parameter int COORD_BITS = 13
) ();
    logic                     valid;
    logic                     ready;
    t_req_type                req_type;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [COORD_BITS-1:0]    image_x;
    logic [COORD_BITS-1:0]    image_y;
    logic [COORD_BITS-1:0]    box_left;
    logic [COORD_BITS-1:0]    box_right;
    logic [COORD_BITS-1:0]    box_bottom;
    logic signed [PA_W-1:0]   pixel_area;

    modport source (
        output valid, req_type, coef_index, coef_value, image_x, image_y,
               box_left, box_right, box_bottom, pixel_area,
        input  ready
    );
    modport sink (
        input  valid, req_type, coef_index, coef_value, image_x, image_y,
               box_left, box_right, box_bottom, pixel_area,
        output ready
    );
endinterface

FILE: sv/hbpa_out_if.sv
// result channel: world point, world area and flags
// depends on hbpa_pkg
`timescale 1ns / 1ps

interface hbpa_out_if
    import hbpa_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic [AREA_W-1:0]         world_area;
    logic                      area_valid;
    logic                      divide_fault;

    modport source (
        output valid, world_x, world_y, world_area, area_valid, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, world_x, world_y, world_area, area_valid, divide_fault,
        output ready
    );
endinterface

FILE: sv/hbpa_div.sv
// pipelined restoring divider, one quotient bit per stage
// standalone, no package needed
`timescale 1ns / 1ps

module hbpa_div #(
    parameter int DW = 48,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW-1];
    logic [QW-1:0] r_low [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    genvar g;
    for (g = 0; g < QW; g++) begin : g_step
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quo_in;
        logic [DW:0]   w_t;
        logic [DW:0]   w_d;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_rem_in = i_rem;
            assign w_den_in = i_den;
            assign w_low_in = i_low;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_den_in = r_den[g-1];
            assign w_low_in = r_low[g-1];
            assign w_quo_in = r_quo[g-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign w_t  = {w_rem_in, w_low_in[QW-1]};
        assign w_d  = {1'b0, w_den_in};
        assign w_ge = (w_t >= w_d);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[g] <= {w_quo_in[QW-2:0], w_ge};
            end
        end

        if (g < QW-1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= w_ge ? DW'(w_t - w_d) : w_t[DW-1:0];
                    r_low[g] <= {w_low_in[QW-2:0], 1'b0};
                    r_den[g] <= w_den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

FILE: sv/homography_back_projection_area.sv
// one item per cycle sustained while results are taken
// the six point dividers (32 quotient bits) and the area divider (40), one bit a stage, set the depth
// the whole pipeline advances together; it stalls only while a result waits untaken
// load items write the matrix from stage a as the pipeline advances and give no result
// reset (synchronous, active low) clears valid bits, loads identity, zero shifts, area on
`timescale 1ns / 1ps

module homography_back_projection_area
    import hbpa_pkg::*;
#(
    parameter int COORD_BITS     = 13,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    hbpa_in_if.sink               i_req,
    hbpa_out_if.source            o_res
);

    localparam int CB   = COORD_BITS;
    localparam int F    = COEF_FRAC_BITS;
    localparam int SCW  = CB + 2;              // shifted coordinate, signed
    localparam int PRW  = COEF_W + SCW;        // coefficient times coordinate
    localparam int HW   = PRW + 2;             // homogeneous row sum
    localparam int AQ   = WORLD_W - F;         // integer bits of the world value
    localparam int PAM  = PA_W - 1;            // magnitude bits of the pixel area
    localparam int SW   = 2 * WORLD_W + 1;     // sum of two squares
    localparam int PLW  = WORLD_W + PAM;
    localparam int PHW  = (SW - WORLD_W) + PAM;
    localparam int PW   = SW + PAM;
    localparam int SH   = 2 * F - 8;           // Q(2F) times Q0 down to Q8
    localparam int NHW  = PW - SH - AREA_W;
    localparam int DWA  = 2 * CB;              // squared box width
    localparam int CW   = (NHW > DWA) ? NHW : DWA;
    localparam logic [COEF_W-1:0]  COEF_ONE  = COEF_W'(1) << F;
    localparam logic [WORLD_W-1:0] WORLD_MAX = {1'b0, {(WORLD_W-1){1'b1}}};
    localparam logic [WORLD_W-1:0] WORLD_MIN = {1'b1, {(WORLD_W-1){1'b0}}};
    localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

    typedef struct packed {
        logic                   valid;
        logic [NUM_DIV-1:0]     ovf;
        logic [NUM_DIV-1:0]     neg;
        logic [NUM_DIV-1:0]     npos;
        logic [NUM_DIV-1:0]     nneg;
        logic [NUM_DIV-1:0]     dz;
        logic signed [PA_W-1:0] pa;
        logic                   wpos;
        logic [CB-1:0]          w;
        logic                   aen;
    } t_side_div;

    typedef struct packed {
        logic                      valid;
        logic signed [WORLD_W-1:0] wx;
        logic signed [WORLD_W-1:0] wy;
        logic                      fault;
        logic                      avalid;
        logic                      sat;
        logic [PAM-1:0]            pa;
        logic [CB-1:0]             w;
    } t_side_area;

    // whole pipeline moves when the result register can take a new item
    logic r_o_valid;
    logic w_adv;
    logic w_acc;
    assign w_adv       = !r_o_valid || o_res.ready;
    assign w_acc       = i_req.valid && w_adv;
    assign i_req.ready = w_adv;

    // configuration registers
    logic signed [CB-1:0] r_shift_x;
    logic signed [CB-1:0] r_shift_y;
    logic                 r_area_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_area_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHIFT_X: r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data;
                CFG_AREA_EN: r_area_en <= i_cfg_data[0];
                default:     r_area_en <= r_area_en;
            endcase
        end
    end

    // stage a: offsets applied, item registered
    logic                      r_a_valid;
    t_req_type                 r_a_type;
    logic [COEF_IDX_W-1:0]     r_a_idx;
    logic signed [COEF_W-1:0]  r_a_val;
    logic signed [SCW-1:0]     r_a_px, r_a_py, r_a_lf, r_a_rt, r_a_bt;
    logic signed [PA_W-1:0]    r_a_pa;
    logic                      r_a_wpos;
    logic [CB-1:0]             r_a_w;
    logic                      r_a_aen;
    logic signed [SCW-1:0]     w_diff;

    assign w_diff = $signed(SCW'(i_req.box_right)) - $signed(SCW'(i_req.box_left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_type <= i_req.req_type;
            r_a_idx  <= i_req.coef_index;
            r_a_val  <= i_req.coef_value;
            r_a_px   <= $signed(SCW'(i_req.image_x)) + SCW'(r_shift_x);
            r_a_py   <= $signed(SCW'(i_req.image_y)) + SCW'(r_shift_y);
            r_a_lf   <= $signed(SCW'(i_req.box_left)) + SCW'(r_shift_x);
            r_a_rt   <= $signed(SCW'(i_req.box_right)) + SCW'(r_shift_x);
            r_a_bt   <= $signed(SCW'(i_req.box_bottom)) + SCW'(r_shift_y);
            r_a_pa   <= i_req.pixel_area;
            r_a_wpos <= !w_diff[SCW-1] && (w_diff != '0);
            r_a_w    <= w_diff[CB-1:0];
            r_a_aen  <= r_area_en;
        end
    end

    // matrix: written by a load item in stage a, so later objects see it in order
    logic signed [COEF_W-1:0] r_mat [NUM_COEF];
    logic [NUM_COEF-1:0]      w_mat_we;

    always_comb begin
        for (int k = 0; k < NUM_COEF; k++) begin
            w_mat_we[k] = w_adv && r_a_valid && (r_a_type == REQ_LOAD)
                          && (r_a_idx == COEF_IDX_W'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_mat[k] <= (k % 4 == 0) ? COEF_ONE : '0;
            end
        end else begin
            for (int k = 0; k < NUM_COEF; k++) begin
                if (w_mat_we[k]) begin
                    r_mat[k] <= r_a_val;
                end
            end
        end
    end

    // stage b: coefficient products; the left and right corners share the box bottom term
    logic                   r_b_valid;
    logic signed [PRW-1:0]  r_b_pxm [3];
    logic signed [PRW-1:0]  r_b_pym [3];
    logic signed [PRW-1:0]  r_b_lm  [3];
    logic signed [PRW-1:0]  r_b_rm  [3];
    logic signed [PRW-1:0]  r_b_bm  [3];
    logic signed [COEF_W-1:0] r_b_c [3];
    logic signed [PA_W-1:0] r_b_pa;
    logic                   r_b_wpos;
    logic [CB-1:0]          r_b_w;
    logic                   r_b_aen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid && (r_a_type == REQ_OBJECT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_b_pxm[k] <= PRW'(r_mat[3*k])   * PRW'(r_a_px);
                r_b_pym[k] <= PRW'(r_mat[3*k+1]) * PRW'(r_a_py);
                r_b_lm[k]  <= PRW'(r_mat[3*k])   * PRW'(r_a_lf);
                r_b_rm[k]  <= PRW'(r_mat[3*k])   * PRW'(r_a_rt);
                r_b_bm[k]  <= PRW'(r_mat[3*k+1]) * PRW'(r_a_bt);
                r_b_c[k]   <= r_mat[3*k+2];
            end
            r_b_pa   <= r_a_pa;
            r_b_wpos <= r_a_wpos;
            r_b_w    <= r_a_w;
            r_b_aen  <= r_a_aen;
        end
    end

    // stage c: homogeneous row sums for the point and the two bottom corners
    logic                   r_c_valid;
    logic signed [HW-1:0]   r_c_hp [3];
    logic signed [HW-1:0]   r_c_hl [3];
    logic signed [HW-1:0]   r_c_hr [3];
    logic signed [PA_W-1:0] r_c_pa;
    logic                   r_c_wpos;
    logic [CB-1:0]          r_c_w;
    logic                   r_c_aen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_c_hp[k] <= HW'(r_b_pxm[k]) + HW'(r_b_pym[k]) + HW'(r_b_c[k]);
                r_c_hl[k] <= HW'(r_b_lm[k])  + HW'(r_b_bm[k])  + HW'(r_b_c[k]);
                r_c_hr[k] <= HW'(r_b_rm[k])  + HW'(r_b_bm[k])  + HW'(r_b_c[k]);
            end
            r_c_pa   <= r_b_pa;
            r_c_wpos <= r_b_wpos;
            r_c_w    <= r_b_w;
            r_c_aen  <= r_b_aen;
        end
    end

    // six divisions: point x, point y, left x, left y, right x, right y
    logic signed [HW-1:0] w_num [NUM_DIV];
    logic signed [HW-1:0] w_den [NUM_DIV];

    assign w_num[0] = r_c_hp[0];
    assign w_num[1] = r_c_hp[1];
    assign w_num[2] = r_c_hl[0];
    assign w_num[3] = r_c_hl[1];
    assign w_num[4] = r_c_hr[0];
    assign w_num[5] = r_c_hr[1];
    assign w_den[0] = r_c_hp[2];
    assign w_den[1] = r_c_hp[2];
    assign w_den[2] = r_c_hl[2];
    assign w_den[3] = r_c_hl[2];
    assign w_den[4] = r_c_hr[2];
    assign w_den[5] = r_c_hr[2];

    // stage d: magnitudes and signs
    logic [HW-1:0] r_d_a [NUM_DIV];
    logic [HW-1:0] r_d_b [NUM_DIV];
    t_side_div     r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
        end else if (w_adv) begin
            r_d_side.valid <= r_c_valid;
            r_d_side.ovf   <= '0;
            for (int j = 0; j < NUM_DIV; j++) begin
                r_d_side.neg[j]  <= w_num[j][HW-1] ^ w_den[j][HW-1];
                r_d_side.npos[j] <= !w_num[j][HW-1] && (w_num[j] != '0);
                r_d_side.nneg[j] <= w_num[j][HW-1];
                r_d_side.dz[j]   <= (w_den[j] == '0);
            end
            r_d_side.pa   <= r_c_pa;
            r_d_side.wpos <= r_c_wpos;
            r_d_side.w    <= r_c_w;
            r_d_side.aen  <= r_c_aen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < NUM_DIV; j++) begin
                r_d_a[j] <= w_num[j][HW-1] ? HW'(-w_num[j]) : HW'(w_num[j]);
                r_d_b[j] <= w_den[j][HW-1] ? HW'(-w_den[j]) : HW'(w_den[j]);
            end
        end
    end

    // stage e: integer-part overflow check and divider setup
    logic [HW-1:0]      r_e_rem [NUM_DIV];
    logic [WORLD_W-1:0] r_e_low [NUM_DIV];
    logic [HW-1:0]      r_e_b   [NUM_DIV];
    t_side_div          r_e_side;
    t_side_div          n_e_side;

    always_comb begin
        n_e_side = r_d_side;
        for (int j = 0; j < NUM_DIV; j++) begin
            n_e_side.ovf[j] = ((r_d_a[j] >> AQ) >= r_d_b[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side <= '0;
        end else if (w_adv) begin
            r_e_side <= n_e_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < NUM_DIV; j++) begin
                r_e_rem[j] <= r_d_a[j] >> AQ;
                r_e_low[j] <= {r_d_a[j][AQ-1:0], {F{1'b0}}};
                r_e_b[j]   <= r_d_b[j];
            end
        end
    end

    logic [WORLD_W-1:0] w_quo [NUM_DIV];

    genvar gj;
    for (gj = 0; gj < NUM_DIV; gj++) begin : g_div
        hbpa_div #(
            .DW (HW),
            .QW (WORLD_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (r_e_rem[gj]),
            .i_low (r_e_low[gj]),
            .i_den (r_e_b[gj]),
            .o_quo (w_quo[gj])
        );
    end

    // flags travel beside the divider
    t_side_div r_dly_div [WORLD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORLD_W; i++) begin
                r_dly_div[i] <= '0;
            end
        end else if (w_adv) begin
            r_dly_div[0] <= r_e_side;
            for (int i = 1; i < WORLD_W; i++) begin
                r_dly_div[i] <= r_dly_div[i-1];
            end
        end
    end

    // stage f: sign, saturation, zero divisor handling
    t_side_div                 w_fs;
    logic signed [WORLD_W-1:0] n_f_w [NUM_DIV];
    logic signed [WORLD_W-1:0] r_f_w [NUM_DIV];
    t_side_div                 r_f_side;

    assign w_fs = r_dly_div[WORLD_W-1];

    always_comb begin
        logic [WORLD_W:0] mag;
        for (int j = 0; j < NUM_DIV; j++) begin
            mag = w_fs.ovf[j] ? {1'b1, {WORLD_W{1'b0}}} : {1'b0, w_quo[j]};
            if (w_fs.dz[j]) begin
                n_f_w[j] = w_fs.npos[j] ? WORLD_MAX : (w_fs.nneg[j] ? WORLD_MIN : '0);
            end else if (w_fs.neg[j]) begin
                n_f_w[j] = (mag >= {1'b0, WORLD_MIN}) ? WORLD_MIN
                                                      : WORLD_W'((WORLD_W+1)'(0) - mag);
            end else begin
                n_f_w[j] = (mag > {1'b0, WORLD_MAX}) ? WORLD_MAX : mag[WORLD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side <= '0;
        end else if (w_adv) begin
            r_f_side <= w_fs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < NUM_DIV; j++) begin
                r_f_w[j] <= n_f_w[j];
            end
        end
    end

    // stage g: corner differences, fault and area validity
    logic signed [WORLD_W:0] r_g_dx, r_g_dy;
    t_side_area              r_g_side;
    logic                    w_cz;

    assign w_cz = r_f_side.dz[2] || r_f_side.dz[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_side <= '0;
        end else if (w_adv) begin
            r_g_side.valid  <= r_f_side.valid;
            r_g_side.wx     <= r_f_w[0];
            r_g_side.wy     <= r_f_w[1];
            r_g_side.fault  <= r_f_side.dz[0] || (r_f_side.aen && w_cz);
            r_g_side.avalid <= r_f_side.aen && !w_cz && r_f_side.wpos
                               && !r_f_side.pa[PA_W-1];
            r_g_side.sat    <= 1'b0;
            r_g_side.pa     <= r_f_side.pa[PAM-1:0];
            r_g_side.w      <= r_f_side.w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_dx <= (WORLD_W+1)'(r_f_w[4]) - (WORLD_W+1)'(r_f_w[2]);
            r_g_dy <= (WORLD_W+1)'(r_f_w[5]) - (WORLD_W+1)'(r_f_w[3]);
        end
    end

    // stage h: magnitudes of the corner distance
    logic [WORLD_W-1:0] r_h_ux, r_h_uy;
    t_side_area         r_h_side;

    // stage i: squares and squared box width
    logic [2*WORLD_W-1:0] r_i_sx, r_i_sy;
    logic [DWA-1:0]       r_i_den;
    t_side_area           r_i_side;

    // stage j: squared distance
    logic [SW-1:0]  r_j_s;
    logic [DWA-1:0] r_j_den;
    t_side_area     r_j_side;

    // stage k: partial products with the pixel area
    logic [PLW-1:0] r_k_plo;
    logic [PHW-1:0] r_k_phi;
    logic [DWA-1:0] r_k_den;
    t_side_area     r_k_side;

    // stage l: full product
    logic [PW-1:0]  r_l_p;
    logic [DWA-1:0] r_l_den;
    t_side_area     r_l_side;

    // stage m: scale to q8, saturation check, divider setup
    logic [DWA-1:0]    r_m_rem;
    logic [AREA_W-1:0] r_m_low;
    logic [DWA-1:0]    r_m_den;
    t_side_area        r_m_side;
    t_side_area        n_m_side;
    logic [NHW-1:0]    w_nh;

    assign w_nh = r_l_p[PW-1:SH+AREA_W];

    always_comb begin
        n_m_side     = r_l_side;
        n_m_side.sat = (CW'(w_nh) >= CW'(r_l_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_side <= '0;
            r_i_side <= '0;
            r_j_side <= '0;
            r_k_side <= '0;
            r_l_side <= '0;
            r_m_side <= '0;
        end else if (w_adv) begin
            r_h_side <= r_g_side;
            r_i_side <= r_h_side;
            r_j_side <= r_i_side;
            r_k_side <= r_j_side;
            r_l_side <= r_k_side;
            r_m_side <= n_m_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_ux  <= WORLD_W'(r_g_dx[WORLD_W] ? -r_g_dx : r_g_dx);
            r_h_uy  <= WORLD_W'(r_g_dy[WORLD_W] ? -r_g_dy : r_g_dy);
            r_i_sx  <= (2*WORLD_W)'(r_h_ux) * (2*WORLD_W)'(r_h_ux);
            r_i_sy  <= (2*WORLD_W)'(r_h_uy) * (2*WORLD_W)'(r_h_uy);
            r_i_den <= DWA'(r_h_side.w) * DWA'(r_h_side.w);
            r_j_s   <= SW'(r_i_sx) + SW'(r_i_sy);
            r_j_den <= r_i_den;
            r_k_plo <= PLW'(r_j_s[WORLD_W-1:0]) * PLW'(r_j_side.pa);
            r_k_phi <= PHW'(r_j_s[SW-1:WORLD_W]) * PHW'(r_j_side.pa);
            r_k_den <= r_j_den;
            r_l_p   <= (PW'(r_k_phi) << WORLD_W) + PW'(r_k_plo);
            r_l_den <= r_k_den;
            r_m_rem <= DWA'(w_nh);
            r_m_low <= r_l_p[SH+AREA_W-1:SH];
            r_m_den <= r_l_den;
        end
    end

    logic [AREA_W-1:0] w_area_quo;

    hbpa_div #(
        .DW (DWA),
        .QW (AREA_W)
    ) u_area_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem (r_m_rem),
        .i_low (r_m_low),
        .i_den (r_m_den),
        .o_quo (w_area_quo)
    );

    t_side_area r_dly_area [AREA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AREA_W; i++) begin
                r_dly_area[i] <= '0;
            end
        end else if (w_adv) begin
            r_dly_area[0] <= r_m_side;
            for (int i = 1; i < AREA_W; i++) begin
                r_dly_area[i] <= r_dly_area[i-1];
            end
        end
    end

    // result register
    t_side_area                w_os;
    logic signed [WORLD_W-1:0] r_o_wx, r_o_wy;
    logic [AREA_W-1:0]         r_o_area;
    logic                      r_o_avalid;
    logic                      r_o_fault;

    assign w_os = r_dly_area[AREA_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= w_os.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_wx     <= w_os.wx;
            r_o_wy     <= w_os.wy;
            r_o_fault  <= w_os.fault;
            r_o_avalid <= w_os.avalid;
            r_o_area   <= !w_os.avalid ? '0 : (w_os.sat ? AREA_MAX : w_area_quo);
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.world_x      = r_o_wx;
    assign o_res.world_y      = r_o_wy;
    assign o_res.world_area   = r_o_area;
    assign o_res.area_valid   = r_o_avalid;
    assign o_res.divide_fault = r_o_fault;

    // an item without a valid area reports zero area
    a_area_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_avalid |-> r_o_area == '0)
        else $error("area not zero for invalid area");

    // an accepted item always lands in stage a
    a_accept_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_a_valid)
        else $error("accepted item missing from stage a");

    // load items never travel past stage a
    a_load_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_a_valid && (r_a_type == REQ_LOAD) |=> !r_b_valid)
        else $error("load item entered the projection pipeline");

endmodule

FILE: test/tb_homography_back_projection_area.sv
// self-checking testbench for homography_back_projection_area
// depends on hbpa_pkg, hbpa_in_if, hbpa_out_if and the block itself
`timescale 1ns / 1ps

module tb_homography_back_projection_area;
    import hbpa_pkg::*;

    localparam int CB      = 13;
    localparam int FRAC    = 16;
    localparam int LATENCY = 85;
    localparam int LIMIT   = 2000000;
    localparam int SETTLE  = LATENCY + 40;
    localparam longint unsigned AREA_MAX = (64'd1 << 40) - 1;

    // one request item as the sender sees it
    typedef struct {
        t_req_type             kind;
        bit [3:0]              idx;
        bit signed [31:0]      coef;
        bit [CB-1:0]           ix, iy, bl, br, bb;
        bit signed [PA_W-1:0]  pa;
    } t_req;

    // one result item
    typedef struct {
        bit signed [31:0] wx, wy;
        bit [39:0]        area;
        bit               av, df;
    } t_res;

    // scoreboard: mirror of the matrix and registers plus pending results
    class projection_board;
        bit signed [31:0] mtx[9];
        longint           shx, shy;
        bit               area_en;
        t_res             pending[$];
        int               errors;

        function void reset_state();
            for (int k = 0; k < 9; k++) mtx[k] = (k % 4 == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
            shx = 0;
            shy = 0;
            area_en = 1;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_index r, bit [CB-1:0] v);
            case (r)
                CFG_SHIFT_X: shx = longint'($signed(v));
                CFG_SHIFT_Y: shy = longint'($signed(v));
                CFG_AREA_EN: area_en = v[0];
                default: ;
            endcase
        endfunction

        function longint row_sum(int k, longint x, longint y);
            return longint'(mtx[3*k]) * x + longint'(mtx[3*k+1]) * y + longint'(mtx[3*k+2]);
        endfunction

        // signed quotient with FRAC fraction bits, truncated toward zero, saturated
        function bit signed [31:0] fixed_quot(longint num, longint den);
            bit [63:0] a, b, r, mag;
            bit        neg;
            a = num < 0 ? -num : num;
            b = den < 0 ? -den : den;
            neg = (num < 0) != (den < 0);
            mag = a / b;
            r = a % b;
            if (mag >= (64'd1 << (32 - FRAC))) begin
                mag = 64'd1 << 32;
            end else begin
                for (int i = 0; i < FRAC; i++) begin
                    r = r << 1;
                    mag = mag << 1;
                    if (r >= b) begin
                        r = r - b;
                        mag[0] = 1'b1;
                    end
                end
            end
            if (neg) return (mag >= (64'd1 << 31)) ? 32'sh80000000 : -$signed(mag[31:0]);
            return (mag > 64'h7fffffff) ? 32'sh7fffffff : $signed(mag[31:0]);
        endfunction

        // maps (x, y, 1); returns 1 on a zero homogeneous term
        function bit map_point(longint x, longint y, output bit signed [31:0] wx,
                               output bit signed [31:0] wy);
            longint h0, h1, h2;
            h0 = row_sum(0, x, y);
            h1 = row_sum(1, x, y);
            h2 = row_sum(2, x, y);
            if (h2 == 0) begin
                wx = h0 > 0 ? 32'sh7fffffff : (h0 < 0 ? 32'sh80000000 : 32'sd0);
                wy = h1 > 0 ? 32'sh7fffffff : (h1 < 0 ? 32'sh80000000 : 32'sd0);
                return 1'b1;
            end
            wx = fixed_quot(h0, h2);
            wy = fixed_quot(h1, h2);
            return 1'b0;
        endfunction

        // pixel area times squared corner distance over squared width
        function bit [39:0] world_area_of(longint pa, bit signed [31:0] x0,
                                          bit signed [31:0] y0, bit signed [31:0] x1,
                                          bit signed [31:0] y1, longint w);
            bit [127:0] ux, uy, num, q;
            longint     dx, dy;
            dx = longint'(x1) - longint'(x0);
            dy = longint'(y1) - longint'(y0);
            ux = 128'(dx < 0 ? -dx : dx);
            uy = 128'(dy < 0 ? -dy : dy);
            num = ((ux * ux + uy * uy) * 128'(pa)) >> (2 * FRAC - 8);
            q = num / (128'(w) * 128'(w));
            return (q > AREA_MAX) ? AREA_MAX[39:0] : q[39:0];
        endfunction

        // called for every accepted request item
        function void note_request(t_req it);
            longint    px, py, lf, rt, bt, w;
            t_res      e;
            bit        cf;
            bit signed [31:0] x0, y0, x1, y1;
            if (it.kind == REQ_LOAD) begin
                if (it.idx < NUM_COEF) mtx[it.idx] = it.coef;
                return;
            end
            px = longint'(it.ix) + shx;
            py = longint'(it.iy) + shy;
            lf = longint'(it.bl) + shx;
            rt = longint'(it.br) + shx;
            bt = longint'(it.bb) + shy;
            w = rt - lf;
            e.area = '0;
            e.av = 1'b0;
            e.df = map_point(px, py, e.wx, e.wy);
            if (area_en) begin
                cf = map_point(lf, bt, x0, y0);
                cf = map_point(rt, bt, x1, y1) | cf;
                if (cf) e.df = 1'b1;
                if (!cf && w > 0 && it.pa >= 0) begin
                    e.area = world_area_of(longint'(it.pa), x0, y0, x1, y1, w);
                    e.av = 1'b1;
                end
            end
            pending.push_back(e);
        endfunction

        // called for every accepted result item
        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.wx !== e.wx) begin
                $error("world_x expected %0d got %0d", e.wx, got.wx);
                errors++;
            end
            if (got.wy !== e.wy) begin
                $error("world_y expected %0d got %0d", e.wy, got.wy);
                errors++;
            end
            if (got.area !== e.area) begin
                $error("world_area expected %0d got %0d", e.area, got.area);
                errors++;
            end
            if (got.av !== e.av) begin
                $error("area_valid expected %0d got %0d", e.av, got.av);
                errors++;
            end
            if (got.df !== e.df) begin
                $error("divide_fault expected %0d got %0d", e.df, got.df);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CB-1:0] i_cfg_data;

    hbpa_in_if #(.COORD_BITS(CB)) req_if ();
    hbpa_out_if res_if ();

    homography_back_projection_area #(
        .COORD_BITS(CB),
        .COEF_FRAC_BITS(FRAC)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    projection_board board = new();

    // idling controls shared by sender and receiver
    bit tx_no_gaps;
    bit rx_no_gaps;
    bit rx_hold_req;
    int unsigned cycle_cnt;

    always #5 i_clk = ~i_clk;

    // run limit: a hang anywhere ends here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // writes one register; enable is dropped by the caller
    task automatic write_reg(t_cfg_index r, bit [CB-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        board.set_reg(r, v);
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(bit [CB-1:0] sx, bit [CB-1:0] sy, bit ae);
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_AREA_EN, {{(CB-1){1'b0}}, ae});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offers one item after a random gap and waits for the handshake
    task automatic send_item(t_req it);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= it.kind;
        req_if.coef_index <= it.idx;
        req_if.coef_value <= it.coef;
        req_if.image_x <= it.ix;
        req_if.image_y <= it.iy;
        req_if.box_left <= it.bl;
        req_if.box_right <= it.br;
        req_if.box_bottom <= it.bb;
        req_if.pixel_area <= it.pa;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(it);
    endtask

    task automatic load_coef(int k, bit signed [31:0] v);
        t_req it;
        it = '{kind: REQ_LOAD, idx: k[3:0], coef: v, default: '0};
        send_item(it);
    endtask

    task automatic send_object(bit [CB-1:0] ix, bit [CB-1:0] iy, bit [CB-1:0] bl,
                               bit [CB-1:0] br, bit [CB-1:0] bb, bit signed [PA_W-1:0] pa);
        t_req it;
        it.kind = REQ_OBJECT;
        it.idx = 4'($urandom);
        it.coef = $urandom;
        it.ix = ix;
        it.iy = iy;
        it.bl = bl;
        it.br = br;
        it.bb = bb;
        it.pa = pa;
        send_item(it);
    endtask

    // sender pauses until every expected result is back, then lets the pipe drain
    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // random coefficient: mostly a well-behaved ground mapping, sometimes anything
    function automatic bit signed [31:0] rand_coef(int k);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom;
        if (sel == 1) return 32'sd0;
        if (k == 6 || k == 7) return $signed($urandom_range(0, 64)) - 32;
        if (k == 8) return $signed($urandom_range(1 << 14, 1 << 18));
        return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    task automatic random_matrix();
        for (int k = 0; k < NUM_COEF; k++) begin
            // a stray load beyond the last coefficient now and then
            if ($urandom_range(0, 9) == 0) load_coef($urandom_range(NUM_COEF, 15), $urandom);
            load_coef(k, rand_coef(k));
        end
        // a degenerate bottom row gives zero divisors everywhere
        if ($urandom_range(0, 7) == 0) begin
            load_coef(6, 32'sd0);
            load_coef(7, 32'sd0);
            load_coef(8, 32'sd0);
        end
    endtask

    task automatic random_object();
        bit [CB-1:0]           l, r;
        bit signed [PA_W-1:0]  pa;
        l = CB'($urandom);
        r = CB'($urandom);
        // mostly well-ordered boxes so the area path is exercised
        if ($urandom_range(0, 4) != 0 && l > r) {l, r} = {r, l};
        case ($urandom_range(0, 9))
            0: pa = -27'sd1;
            1: pa = PA_W'((1 << 26) - 1);
            2: pa = PA_W'($urandom_range(0, 255));
            default: pa = PA_W'($urandom_range(0, (1 << 26) - 1));
        endcase
        send_object(CB'($urandom), CB'($urandom), l, r, CB'($urandom), pa);
    endtask

    // random phase: new matrix every so often, objects in between
    task automatic random_phase(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 80 == 0) random_matrix();
            random_object();
            sent++;
        end
    endtask

    // receiver: random ready gaps, an optional long hold-off, checks every result
    initial begin
        t_res got;
        int   gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = rx_no_gaps ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do begin
                @(posedge i_clk);
                if (!(res_if.valid && res_if.ready) && rx_hold_req) begin
                    // long stall so the pipeline fills and stops taking items
                    res_if.ready <= 1'b0;
                    repeat (400) @(posedge i_clk);
                    rx_hold_req = 1'b0;
                    res_if.ready <= 1'b1;
                    @(posedge i_clk);
                end
            end while (!(res_if.valid && res_if.ready));
            got.wx = res_if.world_x;
            got.wy = res_if.world_y;
            got.area = res_if.world_area;
            got.av = res_if.area_valid;
            got.df = res_if.divide_fault;
            board.check_result(got);
        end
    end

    // stimulus
    initial begin
        cycle_cnt = 0;
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
        rx_hold_req = 1'b0;
        board.reset_state();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_SHIFT_X;
        i_cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.req_type <= REQ_LOAD;
        req_if.coef_index <= '0;
        req_if.coef_value <= '0;
        req_if.image_x <= '0;
        req_if.image_y <= '0;
        req_if.box_left <= '0;
        req_if.box_right <= '0;
        req_if.box_bottom <= '0;
        req_if.pixel_area <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity matrix, no shift, area on
        write_all_regs('0, '0, 1'b1);
        send_object('0, '0, '0, '0, '0, '0);
        send_object('1, '1, 13'd0, '1, '1, PA_W'((1 << 26) - 1));
        send_object(13'd100, 13'd200, 13'd50, 13'd60, 13'd300, 27'sd1000);
        // zero width, negative width, unknown area
        send_object(13'd10, 13'd10, 13'd40, 13'd40, 13'd20, 27'sd500);
        send_object(13'd10, 13'd10, 13'd41, 13'd40, 13'd20, 27'sd500);
        send_object(13'd10, 13'd10, 13'd10, 13'd90, 13'd20, -27'sd1);
        // loads past the last coefficient are ignored
        load_coef(9, 32'sh12345678);
        load_coef(15, 32'sh80000000);
        send_object(13'd7, 13'd9, 13'd1, 13'd8, 13'd9, 27'sd64);
        // extreme coefficients drive the world values into saturation
        load_coef(0, 32'sh7fffffff);
        load_coef(4, 32'sh80000000);
        send_object('1, '1, 13'd0, '1, '1, 27'sd12345);
        // zero divisor: bottom row cleared, numerator positive, negative and zero
        load_coef(8, 32'sd0);
        send_object(13'd0, 13'd0, 13'd0, 13'd5, 13'd0, 27'sd10);
        send_object(13'd3, 13'd3, 13'd2, 13'd9, 13'd4, 27'sd10);
        load_coef(0, 32'sh80000000);
        send_object(13'd3, 13'd0, 13'd2, 13'd9, 13'd0, 27'sd10);
        // back to identity
        load_coef(0, 32'sh00010000);
        load_coef(4, 32'sh00010000);
        load_coef(8, 32'sh00010000);
        send_object(13'd20, 13'd30, 13'd5, 13'd25, 13'd40, 27'sd3000);
        drain();

        // phase 1: extreme shifts, full gaps on both sides
        write_all_regs(13'h1000, 13'h0fff, 1'b1);
        random_phase(400);
        drain();

        // phase 2: area off, sender streams while the receiver holds off
        write_all_regs(13'h0fff, 13'h1000, 1'b0);
        tx_no_gaps = 1'b1;
        rx_hold_req = 1'b1;
        random_phase(400);
        tx_no_gaps = 1'b0;
        drain();

        // phase 3: no shift, receiver always ready
        write_all_regs('0, '0, 1'b1);
        rx_no_gaps = 1'b1;
        random_phase(400);
        rx_no_gaps = 1'b0;
        drain();

        // phase 4: random shifts
        write_all_regs(CB'($urandom), CB'($urandom), 1'b1);
        random_phase(400);
        drain();

        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
